@@ rtl/ps2_scancode_to_held_keys_core_defines.svh @@
// ----------------------------------------------------------------------------
// ps2_scancode_to_held_keys_core_defines
// assertion macros shared by the scancode decoder modules
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_TO_HELD_KEYS_CORE_DEFINES_SVH
`define PS2_SCANCODE_TO_HELD_KEYS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold in the same cycle, checked out of reset
`define PS2SK_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// implication into the next cycle, checked out of reset
`define PS2SK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PS2SK_ASSERT(label, expr, msg)
`define PS2SK_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/ps2sk_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2sk_pkg
// types, codes and the extended-code table of the scancode decoder
// ----------------------------------------------------------------------------
package ps2sk_pkg;

    // special scancode bytes
    localparam logic [7:0] CODE_PREFIX = 8'hE0;
    localparam logic [7:0] CODE_PAUSE  = 8'hE1;
    localparam logic [7:0] CODE_ACK    = 8'hFA;

    // request types
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // number of key slots on the result
    localparam int HELD_SLOTS = 6;

    typedef struct packed {
        logic       req_type;
        logic [7:0] scan_byte;
        logic       from_aux;
        logic [6:0] map_index;
        logic [7:0] map_value;
    } t_in;

    typedef struct packed {
        logic       changed;
        logic [2:0] held_count;
        logic [7:0] held_key_0;
        logic [7:0] held_key_1;
        logic [7:0] held_key_2;
        logic [7:0] held_key_3;
        logic [7:0] held_key_4;
        logic [7:0] held_key_5;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // input transfer, decode and start keymap access
        logic finish;   // keymap data ready, update list and load result
    } t_cmd;

    // extended code remap: {hit, keymap index}
    function automatic logic [7:0] ext_index(input logic [6:0] code);
        logic [7:0] res;
        case (code)
            7'h1C:   res = {1'b1, 7'h60};
            7'h1D:   res = {1'b1, 7'h61};
            7'h35:   res = {1'b1, 7'h62};
            7'h47:   res = {1'b1, 7'h66};
            7'h48:   res = {1'b1, 7'h67};
            7'h4B:   res = {1'b1, 7'h69};
            7'h4D:   res = {1'b1, 7'h6A};
            7'h4F:   res = {1'b1, 7'h6B};
            7'h50:   res = {1'b1, 7'h6C};
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/ps2sk_ram.sv @@
// ----------------------------------------------------------------------------
// ps2sk_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ps2sk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ps2sk_ctrl.sv @@
// ----------------------------------------------------------------------------
// ps2sk_ctrl
// sequencer for input transfer, keymap read and result hand-off
// ----------------------------------------------------------------------------
`include "ps2_scancode_to_held_keys_core_defines.svh"

module ps2sk_ctrl
    import ps2sk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // result register can take a new value
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ, S_HOLD: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a transfer always moves on to the keymap read
    `PS2SK_ASSERT_NEXT(a_accept_to_read, o_cmd.accept, r_state == S_READ,
        "accepted item did not enter read state")
    // a new result appears only at the end of an item
    `PS2SK_ASSERT(a_result_source, !$rose(r_out_valid) ||
        $past(r_state) == S_READ || $past(r_state) == S_HOLD,
        "result valid rose outside item completion")

endmodule

@@ rtl/ps2sk_dpath.sv @@
// ----------------------------------------------------------------------------
// ps2sk_dpath
// byte decode, keymap storage and held key list
// ----------------------------------------------------------------------------
`include "ps2_scancode_to_held_keys_core_defines.svh"

module ps2sk_dpath
    import ps2sk_pkg::*;
#(
    parameter int MAX_HELD     = 6,
    parameter int KEYMAP_DEPTH = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_data,
    output t_out o_out_data
);

    localparam int AW = $clog2(KEYMAP_DEPTH);

    logic [7:0]        ext;
    logic [6:0]        idx;
    logic              idx_ok;
    logic              scan_active;
    logic              is_clear;
    logic              lookup;
    logic              n_prefix;
    logic              wr_en;
    logic              rd_en;
    logic [7:0]        rd_data;
    logic              r_prefix;
    logic              r_lookup;
    logic              r_rel;
    logic              r_vld_rd;
    logic [KEYMAP_DEPTH-1:0] r_map_vld;
    logic [7:0]        key;
    logic              mapped;
    logic [7:0]        r_list [MAX_HELD];
    logic [7:0]        n_list [MAX_HELD];
    logic [2:0]        r_count;
    logic [2:0]        n_count;
    logic [MAX_HELD-1:0] hit;
    logic [MAX_HELD-1:0] shift;
    logic              any_hit;
    logic [7:0]        keys [HELD_SLOTS];
    t_out              r_out;

    // decode of the incoming byte
    always_comb begin
        ext         = ext_index(i_in_data.scan_byte[6:0]);
        scan_active = (i_in_data.req_type == REQ_SCAN) && !i_in_data.from_aux;
        is_clear    = i_in_data.scan_byte inside {CODE_PAUSE, CODE_ACK};
        idx         = r_prefix ? ext[6:0] : i_in_data.scan_byte[6:0];
        idx_ok      = (r_prefix ? ext[7] : 1'b1) && (int'(idx) < KEYMAP_DEPTH);
        lookup      = scan_active && (i_in_data.scan_byte != CODE_PREFIX) && !is_clear
                      && idx_ok;
        n_prefix    = r_prefix;
        if (scan_active) begin
            n_prefix = (i_in_data.scan_byte == CODE_PREFIX);
        end
        wr_en = i_cmd.accept && (i_in_data.req_type == REQ_MAP)
                && (int'(i_in_data.map_index) < KEYMAP_DEPTH);
        rd_en = i_cmd.accept && lookup;
    end

    // keymap storage
    ps2sk_ram #(
        .WIDTH (8),
        .DEPTH (KEYMAP_DEPTH)
    ) u_keymap (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_data.map_index[AW-1:0]),
        .i_wr_data (i_in_data.map_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // keymap entry valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (wr_en) begin
            r_map_vld[i_in_data.map_index[AW-1:0]] <= 1'b1;
        end
    end

    // prefix flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
        end else if (i_cmd.accept) begin
            r_prefix <= n_prefix;
        end
    end

    // per item decode results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup <= 1'b0;
        end else if (i_cmd.accept) begin
            r_lookup <= lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rel <= i_in_data.scan_byte[7];
        end
        if (rd_en) begin
            r_vld_rd <= r_map_vld[idx[AW-1:0]];
        end
    end

    // mapped key code
    assign key    = (r_lookup && r_vld_rd) ? rd_data : 8'h00;
    assign mapped = (key != 8'h00);

    // held list match and release shift mask
    always_comb begin
        logic run;
        run = 1'b0;
        for (int i = 0; i < MAX_HELD; i++) begin
            hit[i]   = (3'(i) < r_count) && (r_list[i] == key);
            run      = run | hit[i];
            shift[i] = run;
        end
        any_hit = run;
    end

    // held list update
    always_comb begin
        n_list  = r_list;
        n_count = r_count;
        if (mapped) begin
            if (r_rel) begin
                if (any_hit) begin
                    for (int j = 0; j < MAX_HELD; j++) begin
                        if (shift[j]) begin
                            if (j < MAX_HELD - 1) begin
                                n_list[j] = r_list[j+1];
                            end else begin
                                n_list[j] = 8'h00;
                            end
                        end
                    end
                    n_count = r_count - 3'd1;
                end
            end else if (!any_hit && (int'(r_count) < MAX_HELD)) begin
                for (int j = 0; j < MAX_HELD; j++) begin
                    if (3'(j) == r_count) begin
                        n_list[j] = key;
                    end
                end
                n_count = r_count + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            for (int j = 0; j < MAX_HELD; j++) begin
                r_list[j] <= 8'h00;
            end
        end else if (i_cmd.finish) begin
            r_count <= n_count;
            r_list  <= n_list;
        end
    end

    // spread the list onto the fixed result slots
    always_comb begin
        for (int k = 0; k < HELD_SLOTS; k++) begin
            keys[k] = 8'h00;
        end
        for (int k = 0; k < MAX_HELD; k++) begin
            keys[k] = n_list[k];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.changed    <= mapped;
            r_out.held_count <= n_count;
            r_out.held_key_0 <= keys[0];
            r_out.held_key_1 <= keys[1];
            r_out.held_key_2 <= keys[2];
            r_out.held_key_3 <= keys[3];
            r_out.held_key_4 <= keys[4];
            r_out.held_key_5 <= keys[5];
        end
    end

    assign o_out_data = r_out;

    // list never grows past its capacity
    `PS2SK_ASSERT(a_count_bound, int'(r_count) <= MAX_HELD,
        "held count above capacity")
    // the list only moves at item completion
    `PS2SK_ASSERT_NEXT(a_count_stable, !i_cmd.finish, $stable(r_count),
        "held count changed outside item completion")

endmodule

@@ rtl/ps2_scancode_to_held_keys_core.sv @@
// ----------------------------------------------------------------------------
// ps2_scancode_to_held_keys_core
// ps/2 set-1 scancode decoder with a loadable keymap and six key rollover
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) carries either a
//   scancode byte from the controller or a write of one keymap entry.
//   output channel (o_out_valid / i_out_ready / o_out_data) returns one
//   result per item: changed flag, held count and the held key slots.
//   item steps: the first step decodes the byte and reads the keymap ram,
//   the second takes the registered ram data and updates the held list into
//   the result register. a new item is taken only once the last one is done.
//   o_in_ready is high whenever no item is in progress, also while a result
//   waits; if the receiver stalls, the next item is held after its keymap
//   read until the result register frees, and input stays blocked meanwhile.
//   reset: synchronous, active low; clears the prefix flag, the held list and
//   the keymap valid bits, so every entry reads as zero until written.
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module ps2_scancode_to_held_keys_core
    import ps2sk_pkg::*;
#(
    parameter int MAX_HELD     = 6,
    parameter int KEYMAP_DEPTH = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;

    // sequencer
    ps2sk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // decode, keymap and held list
    ps2sk_dpath #(
        .MAX_HELD     (MAX_HELD),
        .KEYMAP_DEPTH (KEYMAP_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
